[rtl/core/tbsc_pkg.sv]
// shared constants and the arctangent table for the track bend sign check
// no dependencies; every other file of the block refers to this package
`default_nettype none

package tbsc_pkg;

  // default widths of the angle and coordinate datapaths
  localparam int ANGLE_BITS_DEF = 16;
  localparam int COORD_BITS_DEF = 16;

  // vectoring steps and prescale of the coordinates before the first step
  localparam int CORDIC_STEPS   = 32;
  localparam int PRESCALE_SHIFT = 24;

  // angle accumulator, 2^32 per turn
  localparam int ZACC_BITS = 32;
  localparam logic [ZACC_BITS-1:0] HALF_TURN = 32'h8000_0000;

  // number of difference vectors of one candidate
  localparam int NUM_VEC = 3;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_MIN_PRODUCT = 1'b0;

  // output saturation limits
  localparam logic signed [31:0] PROD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] PROD_MIN = 32'sh8000_0000;

  // atan(2^-i) at 2^32 per turn, rounded to integers
  function automatic logic [ZACC_BITS-1:0] atan_step(input int unsigned i);
    logic [ZACC_BITS-1:0] r;
    unique case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/tbsc_prep.sv]
// input stage: sign extension, difference vectors, prescale and half-turn pre-rotation
// depends on tbsc_pkg
`default_nettype none

module tbsc_prep #(
  parameter int COORD_BITS = tbsc_pkg::COORD_BITS_DEF,
  parameter int W          = tbsc_pkg::COORD_BITS_DEF + 28
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [8*COORD_BITS-1:0]              in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [W-1:0]                       out_x [tbsc_pkg::NUM_VEC],
  output logic signed [W-1:0]                       out_y [tbsc_pkg::NUM_VEC],
  output logic [tbsc_pkg::ZACC_BITS-1:0]            out_z [tbsc_pkg::NUM_VEC],
  output logic [tbsc_pkg::NUM_VEC-1:0]              out_zero
);

  logic signed [W-1:0]                  x_next [tbsc_pkg::NUM_VEC];
  logic signed [W-1:0]                  y_next [tbsc_pkg::NUM_VEC];
  logic [tbsc_pkg::ZACC_BITS-1:0]       z_next [tbsc_pkg::NUM_VEC];
  logic [tbsc_pkg::NUM_VEC-1:0]         zero_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    logic signed [COORD_BITS-1:0] ax, ay, bx, by;
    logic signed [COORD_BITS:0]   dx, dy;
    logic signed [W-1:0]          sx, sy;
    for (int k = 0; k < tbsc_pkg::NUM_VEC; k++) begin
      ax = $signed(in_data[(2*k)*COORD_BITS +: COORD_BITS]);
      ay = $signed(in_data[(2*k+1)*COORD_BITS +: COORD_BITS]);
      bx = $signed(in_data[(2*k+2)*COORD_BITS +: COORD_BITS]);
      by = $signed(in_data[(2*k+3)*COORD_BITS +: COORD_BITS]);
      dx = (COORD_BITS+1)'(bx) - (COORD_BITS+1)'(ax);
      dy = (COORD_BITS+1)'(by) - (COORD_BITS+1)'(ay);
      sx = W'(dx) <<< tbsc_pkg::PRESCALE_SHIFT;
      sy = W'(dy) <<< tbsc_pkg::PRESCALE_SHIFT;
      zero_next[k] = (dx == '0) && (dy == '0);
      // left half plane: turn by half a turn first
      if (dx < 0) begin
        x_next[k] = -sx;
        y_next[k] = -sy;
        z_next[k] = tbsc_pkg::HALF_TURN;
      end else begin
        x_next[k] = sx;
        y_next[k] = sy;
        z_next[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
      out_zero <= zero_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tbsc_cordic_cell.sv]
// one vectoring step of the arctangent chain, applied to all three vectors
// depends on tbsc_pkg
`default_nettype none

module tbsc_cordic_cell #(
  parameter int STEP = 0,
  parameter int W    = tbsc_pkg::COORD_BITS_DEF + 28
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [W-1:0]                  in_x [tbsc_pkg::NUM_VEC],
  input  wire logic signed [W-1:0]                  in_y [tbsc_pkg::NUM_VEC],
  input  wire logic [tbsc_pkg::ZACC_BITS-1:0]       in_z [tbsc_pkg::NUM_VEC],
  input  wire logic [tbsc_pkg::NUM_VEC-1:0]         in_zero,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [W-1:0]                       out_x [tbsc_pkg::NUM_VEC],
  output logic signed [W-1:0]                       out_y [tbsc_pkg::NUM_VEC],
  output logic [tbsc_pkg::ZACC_BITS-1:0]            out_z [tbsc_pkg::NUM_VEC],
  output logic [tbsc_pkg::NUM_VEC-1:0]              out_zero
);

  localparam logic [tbsc_pkg::ZACC_BITS-1:0] ATAN = tbsc_pkg::atan_step(STEP);

  logic signed [W-1:0]            x_next [tbsc_pkg::NUM_VEC];
  logic signed [W-1:0]            y_next [tbsc_pkg::NUM_VEC];
  logic [tbsc_pkg::ZACC_BITS-1:0] z_next [tbsc_pkg::NUM_VEC];

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    logic signed [W-1:0] xs, ys;
    for (int k = 0; k < tbsc_pkg::NUM_VEC; k++) begin
      xs = in_x[k] >>> STEP;
      ys = in_y[k] >>> STEP;
      // rotate towards the x axis; y equal to zero goes counter-clockwise
      if (in_y[k] > 0) begin
        x_next[k] = in_x[k] + ys;
        y_next[k] = in_y[k] - xs;
        z_next[k] = in_z[k] + ATAN;
      end else begin
        x_next[k] = in_x[k] - ys;
        y_next[k] = in_y[k] + xs;
        z_next[k] = in_z[k] - ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
      out_zero <= in_zero;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tbsc_finish.sv]
// back end: angle rounding, turning angles, product, threshold and saturation
// depends on tbsc_pkg
`default_nettype none

module tbsc_finish #(
  parameter int ANGLE_BITS = tbsc_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [tbsc_pkg::ZACC_BITS-1:0]       in_z [tbsc_pkg::NUM_VEC],
  input  wire logic [tbsc_pkg::NUM_VEC-1:0]         in_zero,
  input  wire logic signed [31:0]                   min_product,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      compatible,
  output logic signed [31:0]                        angle_product
);

  localparam int ZB = tbsc_pkg::ZACC_BITS;
  localparam int PW = 2 * ANGLE_BITS + 2;
  localparam int CW = (PW > 33) ? PW : 33;
  localparam logic [ZB-1:0]         RND  = ZB'(1) << (31 - ANGLE_BITS);
  localparam logic [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic signed [CW-1:0]  SAT_HI = CW'(tbsc_pkg::PROD_MAX);
  localparam logic signed [CW-1:0]  SAT_LO = CW'(tbsc_pkg::PROD_MIN);

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;

  logic [ANGLE_BITS-1:0]     ang [tbsc_pkg::NUM_VEC];
  logic [ANGLE_BITS-1:0]     ang_next [tbsc_pkg::NUM_VEC];
  logic signed [ANGLE_BITS:0] t1, t2;
  logic signed [ANGLE_BITS:0] t1_next, t2_next;
  logic signed [PW-1:0]      prod;
  logic signed [CW-1:0]      prod_ext;
  logic signed [CW-1:0]      min_ext;

  assign r4 = !v4 || out_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready  = r1;
  assign out_valid = v4;

  // round to nearest, ties upward; a zero vector has azimuth zero
  always_comb begin
    logic [ZB-1:0] zr;
    for (int k = 0; k < tbsc_pkg::NUM_VEC; k++) begin
      zr = in_z[k] + RND;
      ang_next[k] = in_zero[k] ? '0 : zr[ZB-1 -: ANGLE_BITS];
    end
  end

  // wrap into the half-open turn, exactly half a turn positive
  always_comb begin
    logic [ANGLE_BITS-1:0] d1, d2;
    d1 = ang[0] - ang[1];
    d2 = ang[1] - ang[2];
    t1_next = $signed({d1 > HALF, d1});
    t2_next = $signed({d2 > HALF, d2});
  end

  assign prod_ext = CW'(prod);
  assign min_ext  = CW'(min_product);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      ang <= ang_next;
    end
    if (r2 && v1) begin
      t1 <= t1_next;
      t2 <= t2_next;
    end
    if (r3 && v2) begin
      prod <= PW'(t1) * PW'(t2);
    end
    if (r4 && v3) begin
      compatible <= (prod_ext >= min_ext);
      if (prod_ext > SAT_HI) begin
        angle_product <= tbsc_pkg::PROD_MAX;
      end else if (prod_ext < SAT_LO) begin
        angle_product <= tbsc_pkg::PROD_MIN;
      end else begin
        angle_product <= prod_ext[31:0];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/track_bend_sign_check.sv]
// top level of the track bend sign check: stream ports, threshold register, cell chain
// depends on tbsc_pkg, tbsc_prep, tbsc_cordic_cell and tbsc_finish
//
// usage
//   s_* takes one four-hit candidate per transaction; m_* returns one result
//   transaction per candidate, in order. both sides are tvalid/tready streams
//   and a transaction completes when tvalid and tready are high at a clock edge
//   the candidate's three azimuths are found by a row of 32 vectoring cells, one
//   step each, all three vectors side by side; each cell registers its result
//   pipeline: 1 input stage, 32 cells, 4 back-end stages (rounding, turning
//   angles, product, threshold), each with its own output register
//   throughput: one candidate per cycle while m_tready stays high
//   every stage holds its own valid bit, so a stall at m_tready only stops the
//   stages that are full; empty stages behind it keep taking transactions, and
//   s_tready falls only once the whole chain is occupied
//   min_angle_product sits at byte address 0 of the register port; write it only
//   while no candidate is in flight. reset (rst, synchronous) empties the chain
//   and clears min_angle_product to zero
`default_nettype none

module track_bend_sign_check #(
  parameter int ANGLE_BITS = tbsc_pkg::ANGLE_BITS_DEF,
  parameter int COORD_BITS = tbsc_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input candidates
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // hit0_x, hit0_y, hit1_x, hit1_y, hit2_x, hit2_y, hit3_x, hit3_y, COORD_BITS each
  input  wire logic [8*COORD_BITS-1:0]             s_tdata,
  // results
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // compatible (bit 0), angle_product (bits 32:1), zero fill to 40 bits
  output logic [39:0]                              m_tdata,
  // register port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [tbsc_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [tbsc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tbsc_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                     pready
);

  // datapath width: difference, prescale and cordic growth with a spare bit
  localparam int W     = COORD_BITS + 28;
  localparam int STEPS = tbsc_pkg::CORDIC_STEPS;
  localparam int NV    = tbsc_pkg::NUM_VEC;

  logic signed [31:0] min_angle_product;
  logic               reg_sel;
  logic               compatible;
  logic signed [31:0] angle_product;

  // chain links: entry i feeds cell i, entry STEPS feeds the back end
  logic                            cv [STEPS+1];
  logic                            cr [STEPS+1];
  logic signed [W-1:0]             cx [STEPS+1][NV];
  logic signed [W-1:0]             cy [STEPS+1][NV];
  logic [tbsc_pkg::ZACC_BITS-1:0]  cz [STEPS+1][NV];
  logic [NV-1:0]                   czero [STEPS+1];

  // register port: low address bits select byte lanes and are ignored
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == tbsc_pkg::REG_MIN_PRODUCT);
  assign prdata  = reg_sel ? min_angle_product : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_angle_product <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      min_angle_product <= pwdata;
    end
  end

  tbsc_prep #(
    .COORD_BITS (COORD_BITS),
    .W          (W)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_x     (cx[0]),
    .out_y     (cy[0]),
    .out_z     (cz[0]),
    .out_zero  (czero[0])
  );

  // one cell per vectoring step
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    tbsc_cordic_cell #(
      .STEP (i),
      .W    (W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_x      (cx[i]),
      .in_y      (cy[i]),
      .in_z      (cz[i]),
      .in_zero   (czero[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_x     (cx[i+1]),
      .out_y     (cy[i+1]),
      .out_z     (cz[i+1]),
      .out_zero  (czero[i+1])
    );
  end

  tbsc_finish #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_finish (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (cv[STEPS]),
    .in_ready      (cr[STEPS]),
    .in_z          (cz[STEPS]),
    .in_zero       (czero[STEPS]),
    .min_product   (min_angle_product),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .compatible    (compatible),
    .angle_product (angle_product)
  );

  assign m_tdata = {7'b0, angle_product, compatible};

endmodule

`default_nettype wire
